FILE: hdl/wnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wnc_pkg;

    // status codes carried on each result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_SUM = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [15:0] weight;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic [16:0] normalized_weight;
        logic [16:0] cumulative_weight;
        logic        end_of_set;
    } t_out;

    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_PREP,
        S_DIV
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/wnc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, dividend shifted out MSB first.
module wnc_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 22,
    parameter int QUOT_W     = 17
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [QUOT_W-1:0]          o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] r_dq;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_d;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    shifted;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_dq[DIVIDEND_W-1]};
        ge      = shifted >= {1'b0, r_d};
        n_rem   = ge ? DIVISOR_W'(shifted - {1'b0, r_d}) : DIVISOR_W'(shifted);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIVIDEND_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq[QUOT_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/weight_normalize_cumulate.sv
`timescale 1ns / 1ps
`default_nettype none

// Weight normalisation with cumulative sum. Weights are loaded one item per
// cycle while busy is low; each is stored and added to the set's sum, and
// weights beyond DEPTH are dropped and flag the set as overflowed. On the item
// marked last the set closes. A zero sum gives a single zero-sum result on the
// cycle after that item, and loading may carry on at once. Otherwise busy
// rises and one result per stored weight follows, in order. For each, the
// store is read, the divider is loaded, the bit-serial restoring divider
// forms the quotient bit by bit, and the result is registered. Each result is
// shown for exactly one cycle with o_valid high; the receiver cannot stall,
// so it must take every strobe. The weight store needs no clearing after
// reset: only entries written in the current set are read.
module weight_normalize_cumulate #(
    parameter int DEPTH       = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire wnc_pkg::t_in  i_item,
    output logic               o_valid,
    output wnc_pkg::t_out      o_result
);

    import wnc_pkg::*;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int SUM_W    = WEIGHT_BITS + $clog2(DEPTH);   // never wraps
    localparam int DIVD_W   = WEIGHT_BITS + FRAC_BITS;
    localparam int NORM_W   = FRAC_BITS + 1;                  // Q1.FRAC

    // weight store, registered read
    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd_data;

    t_state                 r_state, n_state;
    logic [FILL_W-1:0]      r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic                   r_ovf;
    logic [IDX_W-1:0]       r_idx;
    logic [NORM_W-1:0]      r_cum;
    logic                   r_valid;
    t_out                   r_out;

    logic                   accept;
    logic                   room;
    logic [WEIGHT_BITS-1:0] w;
    logic [SUM_W-1:0]       n_sum;
    logic                   div_start;
    logic                   div_done;
    logic [NORM_W-1:0]      quot;
    logic [NORM_W-1:0]      n_cum;
    logic                   last_entry;

    assign accept     = start && (r_state == S_LOAD);
    assign room       = r_fill < FILL_W'(DEPTH);
    assign w          = WEIGHT_BITS'(i_item.weight);
    assign n_sum      = room ? r_sum + SUM_W'(w) : r_sum;
    assign n_cum      = r_cum + quot;
    assign last_entry = (FILL_W'(r_idx) + FILL_W'(1)) == r_fill;

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            mem[r_fill[IDX_W-1:0]] <= w;
        end
        r_rd_data <= mem[r_idx];
    end

    wnc_div #(
        .DIVIDEND_W (DIVD_W),
        .DIVISOR_W  (SUM_W),
        .QUOT_W     (NORM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rd_data, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // sequencer: load weights, then read / divide / emit per entry
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (accept && i_item.last && (n_sum != '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = last_entry ? S_LOAD : S_READ;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_cum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (accept) begin
                if (i_item.last && (n_sum == '0)) begin
                    // zero-sum set: one zero-sum item, state clears at once
                    r_valid <= 1'b1;
                    r_fill  <= '0;
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    if (room) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                r_idx <= '0;
                r_cum <= '0;
            end else if ((r_state == S_DIV) && div_done) begin
                r_valid <= 1'b1;
                r_cum   <= n_cum;
                if (last_entry) begin
                    r_idx  <= '0;
                    r_fill <= '0;
                    r_sum  <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    // result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && i_item.last && (n_sum == '0)) begin
            r_out.status            <= ST_ZERO_SUM;
            r_out.entry_index       <= '0;
            r_out.normalized_weight <= '0;
            r_out.cumulative_weight <= '0;
            r_out.end_of_set        <= 1'b1;
        end else if ((r_state == S_DIV) && div_done) begin
            r_out.status            <= r_ovf ? ST_OVERFLOW : ST_OK;
            r_out.entry_index       <= 6'(r_idx);
            r_out.normalized_weight <= 17'(quot);
            r_out.cumulative_weight <= 17'(n_cum);
            r_out.end_of_set        <= last_entry;
        end
    end

    assign busy     = r_state != S_LOAD;
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: hdl/wnc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module wnc_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire wnc_pkg::t_in  i_item,
    input wire logic          o_valid,
    input wire wnc_pkg::t_out o_result
);

    import wnc_pkg::*;

    // zero-sum item is fixed in shape
    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_ZERO_SUM)) |->
        (o_result.end_of_set && (o_result.entry_index == '0) &&
         (o_result.normalized_weight == '0) && (o_result.cumulative_weight == '0)))
        else $error("malformed zero-sum item");

    // more items of the set to come keep the block busy
    a_busy_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.end_of_set) |-> busy)
        else $error("busy dropped in the middle of a set");

    a_cum_ge_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.cumulative_weight >= o_result.normalized_weight))
        else $error("cumulative weight below normalised weight");

    // a weight that does not close the set gives no item
    a_no_item_mid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.last) |=> !o_valid)
        else $error("item without a closed set");

endmodule

bind weight_normalize_cumulate wnc_chk u_wnc_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
